### sv/sopm_pkg.sv
// shared constants and types for the second-order pdm modulator
`timescale 1ns / 1ps

package sopm_pkg;

    localparam int WORD_W      = 32;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 5;
    localparam int BIT_CNT_W   = $clog2(WORD_W);
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam int DEF_MAX_OVERSAMPLE = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_OVERSAMPLE_COUNT = CFG_INDEX_W'(1);

    localparam logic [WORD_W-1:0] IDLE_WORD    = 32'h5555_5555;
    localparam logic [WORD_W-1:0] FB_MAG       = 32'h00FE_DCBA;
    localparam logic [WORD_W-1:0] INPUT_OFFSET = 32'h0000_1000;
    localparam logic [7:0]        U8_OFFSET    = 8'h80;

    // feedback state codes
    localparam logic [1:0] FB_ZERO = 2'd0;
    localparam logic [1:0] FB_POS  = 2'd1;
    localparam logic [1:0] FB_NEG  = 2'd2;

    typedef struct packed {
        logic                no_source;
        logic [WORD_W-1:0]   x;
        logic [COUNT_W-1:0]  words;
    } t_job;

endpackage

### sv/sopm_if.sv
// channel interfaces: sample input, pdm word output, configuration writes
`timescale 1ns / 1ps

interface sopm_sample_if;
    import sopm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                no_source;

    modport source (output valid, output sample, output no_source, input ready);
    modport sink   (input valid, input sample, input no_source, output ready);
endinterface

interface sopm_pdm_if;
    import sopm_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pdm_word;
    logic              last;

    modport source (output valid, output pdm_word, output last, input ready);
    modport sink   (input valid, input pdm_word, input last, output ready);
endinterface

interface sopm_cfg_if;
    import sopm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/second_order_pdm_modulator_top.sv
// top level of the second-order pdm modulator
`timescale 1ns / 1ps

// Second-order 1-bit delta-sigma modulator. Each accepted sample beat yields
// oversample_count 32-bit pdm words (0 counts as 1, and counts above
// MAX_OVERSAMPLE, 16 by default, are clamped to it; earliest bit in bit 0,
// last set on the final word). The loop produces one bit per clock while the
// output is not stalled, once the sample is loaded. A no-source sample leaves
// the loop state alone. A two-entry queue lets the next samples be taken
// while the loop is busy; configuration writes are taken every cycle.

module second_order_pdm_modulator_top #(
    parameter int MAX_OVERSAMPLE = sopm_pkg::DEF_MAX_OVERSAMPLE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sopm_sample_if.sink i_in,
    sopm_cfg_if.sink    i_cfg,
    sopm_pdm_if.source  o_out
);
    import sopm_pkg::*;

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    sopm_front #(
        .MAX_OVERSAMPLE(MAX_OVERSAMPLE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    sopm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    sopm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_job   (pop_job),
        .o_out       (o_out)
    );

endmodule

### sv/sopm_front.sv
// front end: configuration registers, sample accept and loop input formation
`timescale 1ns / 1ps

module sopm_front #(
    parameter int MAX_OVERSAMPLE = sopm_pkg::DEF_MAX_OVERSAMPLE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sopm_sample_if.sink         i_in,
    sopm_cfg_if.sink            i_cfg,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output sopm_pkg::t_job      o_push_job
);
    import sopm_pkg::*;

    logic                r_sample_format;
    logic [COUNT_W-1:0]  r_oversample_count;
    logic [SAMPLE_W-1:0] s16;
    logic [COUNT_W-1:0]  words;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format    <= 1'b1;
            r_oversample_count <= COUNT_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SAMPLE_FORMAT:    r_sample_format    <= i_cfg.data[0];
                REG_OVERSAMPLE_COUNT: r_oversample_count <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // u8 minus 128 is the byte with its top bit flipped
        if (r_sample_format) begin
            s16 = i_in.sample;
        end else begin
            s16 = {i_in.sample[7:0] ^ U8_OFFSET, 8'h00};
        end

        if (r_oversample_count == '0) begin
            words = COUNT_W'(1);
        end else if (32'(r_oversample_count) > MAX_OVERSAMPLE) begin
            words = COUNT_W'(MAX_OVERSAMPLE);
        end else begin
            words = r_oversample_count;
        end
    end

    assign o_push_job.no_source = i_in.no_source;
    assign o_push_job.x         = {{8{s16[SAMPLE_W-1]}}, s16, 8'h00} + INPUT_OFFSET;
    assign o_push_job.words     = words;
    assign o_push_valid         = i_in.valid;
    assign i_in.ready           = i_push_ready;

endmodule

### sv/sopm_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps

module sopm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  sopm_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output sopm_pkg::t_job o_pop_job
);
    import sopm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

### sv/sopm_back.sv
// back end: bit-serial second-order loop, word assembly and output register
`timescale 1ns / 1ps

module sopm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  sopm_pkg::t_job i_pop_job,
    sopm_pdm_if.source     o_out
);
    import sopm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PAT  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [WORD_W-1:0]    r_f, n_f;
    logic [WORD_W-1:0]    r_s, n_s;
    logic [1:0]           r_fb, n_fb;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [COUNT_W-1:0]   r_left, n_left;
    logic                 r_full, n_full;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [WORD_W-1:0]    r_out_word, n_out_word;
    logic                 r_out_last, n_out_last;

    // loop input with each feedback value already folded in
    logic [WORD_W-1:0]    r_d_zero, r_d_pos, r_d_neg;
    logic [WORD_W-1:0]    r_y_pos, r_y_neg;

    logic                 pop;
    logic                 out_free;
    logic                 step;
    logic [WORD_W-1:0]    d_sel;
    logic [WORD_W-1:0]    y_sel;
    logic [WORD_W-1:0]    f_new;
    logic [WORD_W-1:0]    s_new;
    logic                 pdm_bit;
    logic [WORD_W-1:0]    word_next;
    logic                 is_last;

    assign pop         = (r_state == ST_IDLE) && i_pop_valid;
    assign o_pop_ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign step        = (r_state == ST_RUN) && !r_full;
    assign is_last     = (r_left == COUNT_W'(1));

    always_comb begin
        case (r_fb)
            FB_POS: begin
                d_sel = r_d_pos;
                y_sel = r_y_pos;
            end
            FB_NEG: begin
                d_sel = r_d_neg;
                y_sel = r_y_neg;
            end
            default: begin
                d_sel = r_d_zero;
                y_sel = r_d_zero;
            end
        endcase
    end

    // second integrator sees first + x - 2*fb, so both sums run side by side
    assign f_new     = r_f + d_sel;
    assign s_new     = r_s + r_f + y_sel;
    assign pdm_bit   = ~s_new[WORD_W-1];
    assign word_next = {pdm_bit, r_word[WORD_W-1:1]};

    always_comb begin
        n_state     = r_state;
        n_f         = r_f;
        n_s         = r_s;
        n_fb        = r_fb;
        n_bit       = r_bit;
        n_left      = r_left;
        n_full      = r_full;
        n_word      = r_word;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_left = i_pop_job.words;
                    n_bit  = '0;
                    n_full = 1'b0;
                    n_state = i_pop_job.no_source ? ST_PAT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (step) begin
                    n_f    = f_new;
                    n_s    = s_new;
                    n_fb   = pdm_bit ? FB_POS : FB_NEG;
                    n_word = word_next;
                    n_bit  = r_bit + BIT_CNT_W'(1);
                    if (r_bit == BIT_CNT_W'(WORD_W - 1)) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_word  = word_next;
                            n_out_last  = is_last;
                            n_left      = r_left - COUNT_W'(1);
                            if (is_last) begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                end else if (out_free) begin
                    // finished word was held back by a stalled output
                    n_full      = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_word  = r_word;
                    n_out_last  = is_last;
                    n_left      = r_left - COUNT_W'(1);
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = IDLE_WORD;
                    n_out_last  = is_last;
                    n_left      = r_left - COUNT_W'(1);
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_f         <= '0;
            r_s         <= '0;
            r_fb        <= FB_ZERO;
            r_bit       <= '0;
            r_left      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_f         <= n_f;
            r_s         <= n_s;
            r_fb        <= n_fb;
            r_bit       <= n_bit;
            r_left      <= n_left;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
        if (pop) begin
            r_d_zero <= i_pop_job.x;
            r_d_pos  <= i_pop_job.x - FB_MAG;
            r_d_neg  <= i_pop_job.x + FB_MAG;
            r_y_pos  <= i_pop_job.x - {FB_MAG[WORD_W-2:0], 1'b0};
            r_y_neg  <= i_pop_job.x + {FB_MAG[WORD_W-2:0], 1'b0};
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.pdm_word = r_out_word;
    assign o_out.last     = r_out_last;

endmodule
